### rtl/lcdsw_pkg.sv
`default_nettype none
package lcdsw_pkg;

	localparam int ADDRESS_BITS_DEF = 6;
	localparam int QUEUE_DEPTH_DEF  = 2;

	localparam int START_ADDRESS_W = 6;
	localparam int BYTE_W          = 8;
	localparam int CMD_HDR_W       = 4;
	localparam int DATA_HDR_W      = 3;

	localparam logic [7:0] CMD_HEADER  = 8'h80;
	localparam logic [7:0] DATA_HEADER = 8'ha0;

	typedef enum logic {
		OP_COMMAND = 1'b0,
		OP_DATA    = 1'b1
	} op_t;

	typedef struct packed {
		logic starts;
		logic ends;
	} frame_flags_t;

endpackage
`default_nettype wire

### rtl/lcdsw_front.sv
`default_nettype none
module lcdsw_front #(
	parameter int ADDRESS_BITS = lcdsw_pkg::ADDRESS_BITS_DEF,
	parameter int FRAME_W      = lcdsw_pkg::DATA_HDR_W + ADDRESS_BITS + lcdsw_pkg::BYTE_W,
	parameter int LEN_W        = $clog2(FRAME_W + 1)
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire logic                                   operation,
	input  wire logic [lcdsw_pkg::BYTE_W-1:0]           command_code,
	input  wire logic [lcdsw_pkg::START_ADDRESS_W-1:0]  start_address,
	input  wire logic [lcdsw_pkg::BYTE_W-1:0]           data_byte,
	input  wire logic                                   last_in_burst,
	output logic      [FRAME_W-1:0]                     frame_word,
	output logic      [LEN_W-1:0]                       frame_len,
	output lcdsw_pkg::frame_flags_t                     frame_flags
);

	localparam int CMD_LEN = lcdsw_pkg::CMD_HDR_W + lcdsw_pkg::BYTE_W;

	logic                    burst_open_q;
	logic [ADDRESS_BITS-1:0] addr_w;
	logic [FRAME_W-1:0]      cmd_word;
	logic [FRAME_W-1:0]      open_word;
	logic [FRAME_W-1:0]      data_word;

	// high address bits beyond the input field go out as zero
	assign addr_w    = ADDRESS_BITS'(start_address);
	assign cmd_word  = FRAME_W'({lcdsw_pkg::CMD_HEADER[7:4], command_code}) << (FRAME_W - CMD_LEN);
	assign open_word = {lcdsw_pkg::DATA_HEADER[7:5], addr_w, data_byte};
	assign data_word = FRAME_W'(data_byte) << (FRAME_W - lcdsw_pkg::BYTE_W);

	always_comb begin
		if (operation == lcdsw_pkg::OP_COMMAND) begin
			frame_word         = cmd_word;
			frame_len          = LEN_W'(CMD_LEN);
			frame_flags.starts = 1'b1;
			frame_flags.ends   = 1'b1;
		end else if (!burst_open_q) begin
			frame_word         = open_word;
			frame_len          = LEN_W'(FRAME_W);
			frame_flags.starts = 1'b1;
			frame_flags.ends   = last_in_burst;
		end else begin
			frame_word         = data_word;
			frame_len          = LEN_W'(lcdsw_pkg::BYTE_W);
			frame_flags.starts = 1'b0;
			frame_flags.ends   = last_in_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_open_q <= 1'b0;
		end else if (accept) begin
			burst_open_q <= (operation == lcdsw_pkg::OP_DATA) && !last_in_burst;
		end
	end

endmodule
`default_nettype wire

### rtl/lcdsw_fifo.sv
`default_nettype none
module lcdsw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lcdsw_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/lcdsw_back.sv
`default_nettype none
module lcdsw_back #(
	parameter int FRAME_W = 17,
	parameter int LEN_W   = $clog2(FRAME_W + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_empty,
	input  wire logic [FRAME_W-1:0]      q_word,
	input  wire logic [LEN_W-1:0]        q_len,
	input  wire lcdsw_pkg::frame_flags_t q_flags,
	output logic                         q_pop,
	input  wire logic                    pop,
	output logic                         empty,
	output logic                         serial_bit,
	output logic                         frame_start,
	output logic                         frame_end,
	output logic                         last
);

	logic [FRAME_W-1:0]      word_q;
	logic [LEN_W-1:0]        cnt_q;
	lcdsw_pkg::frame_flags_t flags_q;
	logic                    first_q;
	logic                    take;

	assign empty       = cnt_q == '0;
	assign take        = !empty && pop;
	assign last        = cnt_q == LEN_W'(1);
	assign serial_bit  = word_q[FRAME_W-1];
	assign frame_start = flags_q.starts && first_q;
	assign frame_end   = flags_q.ends && last;
	// refill in the same cycle the last bit leaves, so bits run back to back
	assign q_pop       = !q_empty && (empty || (take && last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q  <= q_word;
			flags_q <= q_flags;
		end else if (take) begin
			word_q <= word_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else if (q_pop) begin
			cnt_q   <= q_len;
			first_q <= 1'b1;
		end else if (take) begin
			cnt_q   <= cnt_q - 1'b1;
			first_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### rtl/lcd_controller_serial_writer_unit.sv
`default_nettype none
// serial writer for a three-wire segment lcd controller: each accepted transaction
// becomes a run of result transactions, one per serial bit, msb first. a command
// gives 12 bits, a data byte that opens a burst gives 11 + ADDRESS_BITS bits and
// a data byte inside a burst gives 8. the back end's shift register delivers one
// bit per cycle while pop is held, with no gap between items when a frame waits
// in the queue; the front end classifies items against the open-burst flag, a queue
// parks up to QUEUE_DEPTH frames ahead of the back end, and full rises once that
// queue is filled. no clearing pass is needed after reset.
module lcd_controller_serial_writer_unit #(
	parameter int ADDRESS_BITS = lcdsw_pkg::ADDRESS_BITS_DEF,
	parameter int QUEUE_DEPTH  = lcdsw_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic                                  operation,
	input  wire logic [lcdsw_pkg::BYTE_W-1:0]          command_code,
	input  wire logic [lcdsw_pkg::START_ADDRESS_W-1:0] start_address,
	input  wire logic [lcdsw_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic                                  last_in_burst,
	output logic                                       empty,
	input  wire logic                                  pop,
	output logic                                       serial_bit,
	output logic                                       frame_start,
	output logic                                       frame_end,
	output logic                                       last
);

	localparam int FRAME_W = lcdsw_pkg::DATA_HDR_W + ADDRESS_BITS + lcdsw_pkg::BYTE_W;
	localparam int LEN_W   = $clog2(FRAME_W + 1);
	localparam int FLG_W   = $bits(lcdsw_pkg::frame_flags_t);
	localparam int DESC_W  = FLG_W + LEN_W + FRAME_W;

	logic                    accept;
	logic [FRAME_W-1:0]      f_word;
	logic [LEN_W-1:0]        f_len;
	lcdsw_pkg::frame_flags_t f_flags;
	logic [DESC_W-1:0]       q_rd;
	logic                    q_empty;
	logic                    q_pop;
	lcdsw_pkg::frame_flags_t q_flags;

	assign accept  = push && !full;
	assign q_flags = q_rd[DESC_W-1 -: FLG_W];

	lcdsw_front #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.FRAME_W      (FRAME_W),
		.LEN_W        (LEN_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.operation     (operation),
		.command_code  (command_code),
		.start_address (start_address),
		.data_byte     (data_byte),
		.last_in_burst (last_in_burst),
		.frame_word    (f_word),
		.frame_len     (f_len),
		.frame_flags   (f_flags)
	);

	lcdsw_fifo #(
		.WIDTH (DESC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data ({f_flags, f_len, f_word}),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.full    (full),
		.empty   (q_empty)
	);

	lcdsw_back #(
		.FRAME_W (FRAME_W),
		.LEN_W   (LEN_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_word      (q_rd[FRAME_W-1:0]),
		.q_len       (q_rd[FRAME_W +: LEN_W]),
		.q_flags     (q_flags),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.serial_bit  (serial_bit),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.last        (last)
	);

endmodule
`default_nettype wire

### rtl/lcdsw_checker.sv
`default_nettype none
module lcdsw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire logic serial_bit,
	input wire logic frame_start,
	input wire logic frame_end,
	input wire logic last
);

	// both queues read as idle while reset is held
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> empty && !full)
		else $error("queue status wrong during reset");

	// a frame only closes on the final bit of an item
	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_end |-> last)
		else $error("frame_end without last");

	// bits of one item follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last |=> !empty)
		else $error("result stream broke inside an item");

	// a new frame never starts in the middle of an item
	a_start_at_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last |=> !frame_start)
		else $error("frame_start inside an item");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(serial_bit) && $stable(last))
		else $error("waiting result changed");

endmodule

bind lcd_controller_serial_writer_unit lcdsw_checker u_lcdsw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.serial_bit  (serial_bit),
	.frame_start (frame_start),
	.frame_end   (frame_end),
	.last        (last)
);
`default_nettype wire

### sim/tb_top.sv
module tb_top;
	import lcdsw_pkg::*;

	localparam int ADDR_W      = ADDRESS_BITS_DEF;
	localparam int TAIL_CYCLES = 60;
	localparam int RAND_ITEMS  = 112;

	// one input transaction; exp_n != 0 means the expected bits are typed in the row
	typedef struct packed {
		op_t         op;
		logic [7:0]  cmd;
		logic [5:0]  addr;
		logic [7:0]  data;
		logic        lib;
		logic [4:0]  exp_n;
		logic [16:0] exp_bits;
		logic        exp_fs;
		logic        exp_fe;
	} stim_t;

	typedef struct packed {
		logic sb;
		logic fs;
		logic fe;
		logic lst;
	} serial_res_t;

	localparam int N_DIRECTED = 18;
	localparam stim_t DIRECTED [N_DIRECTED] = '{
		// command right after reset, all zero
		'{OP_COMMAND, 8'h00, 6'h00, 8'h00, 1'b0, 5'd12, 17'h00800, 1'b1, 1'b1},
		// command with last_in_burst set, which it ignores
		'{OP_COMMAND, 8'hff, 6'h3f, 8'hff, 1'b1, 5'd12, 17'h008ff, 1'b1, 1'b1},
		// single byte burst at the top address
		'{OP_DATA,    8'hff, 6'h3f, 8'hff, 1'b1, 5'd17, 17'h17fff, 1'b1, 1'b1},
		// burst opening at address zero
		'{OP_DATA,    8'hff, 6'h00, 8'h00, 1'b0, 5'd17, 17'h14000, 1'b1, 1'b0},
		// start address ignored inside a burst
		'{OP_DATA,    8'h00, 6'h3f, 8'ha5, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'h00, 6'h15, 8'hff, 1'b1, 5'd8,  17'h000ff, 1'b0, 1'b1},
		'{OP_DATA,    8'h5a, 6'h15, 8'h3c, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		// command breaks into the open burst
		'{OP_COMMAND, 8'h55, 6'h2a, 8'hff, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'h00, 6'h2a, 8'hc3, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'hff, 6'h00, 8'h0f, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'h00, 6'h3f, 8'hf0, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'hff, 6'h01, 8'h81, 1'b1, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_COMMAND, 8'ha5, 6'h3f, 8'hff, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'hff, 6'h01, 8'h80, 1'b1, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'h00, 6'h20, 8'h01, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		// command with last_in_burst during a burst
		'{OP_COMMAND, 8'h00, 6'h3f, 8'h00, 1'b1, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_COMMAND, 8'h3c, 6'h00, 8'h00, 1'b0, 5'd0,  17'h0,     1'b0, 1'b0},
		'{OP_DATA,    8'h00, 6'h2a, 8'h55, 1'b1, 5'd0,  17'h0,     1'b0, 1'b0}
	};

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic       operation;
	logic [7:0] command_code;
	logic [5:0] start_address;
	logic [7:0] data_byte;
	logic       last_in_burst;
	logic       empty;
	logic       pop;
	logic       serial_bit;
	logic       frame_start;
	logic       frame_end;
	logic       last;

	serial_res_t expected_bits[$];
	logic        burst_is_open;
	int          mismatches;
	bit          quiet;

	lcd_controller_serial_writer_unit #(
		.ADDRESS_BITS(ADDR_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.command_code (command_code),
		.start_address(start_address),
		.data_byte    (data_byte),
		.last_in_burst(last_in_burst),
		.empty        (empty),
		.pop          (pop),
		.serial_bit   (serial_bit),
		.frame_start  (frame_start),
		.frame_end    (frame_end),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("lcd_controller_serial_writer_unit test failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void shift_bits(inout serial_res_t q[$], input logic [7:0] value,
			input int count);
		serial_res_t r;
		for (int i = count - 1; i >= 0; i--) begin
			r = '0;
			r.sb = value[i];
			q.push_back(r);
		end
	endfunction

	// bits of one transaction, msb first, with the frame marks
	function automatic void serialize_item(input stim_t s, output serial_res_t q[$]);
		logic starts;
		logic ends;
		starts = 1'b0;
		ends = 1'b0;
		q = {};
		if (s.op == OP_COMMAND) begin
			shift_bits(q, CMD_HEADER >> (8 - CMD_HDR_W), CMD_HDR_W);
			shift_bits(q, s.cmd, BYTE_W);
			starts = 1'b1;
			ends = 1'b1;
			burst_is_open = 1'b0;
		end else begin
			if (!burst_is_open) begin
				shift_bits(q, DATA_HEADER >> (8 - DATA_HDR_W), DATA_HDR_W);
				// address bits above the 6-bit field go out as zero
				shift_bits(q, {2'b00, s.addr}, ADDR_W);
				starts = 1'b1;
			end
			shift_bits(q, s.data, BYTE_W);
			ends = s.lib;
			burst_is_open = !s.lib;
		end
		q[0].fs = starts;
		q[q.size() - 1].fe = ends;
		q[q.size() - 1].lst = 1'b1;
	endfunction

	function automatic stim_t rand_item(input op_t op, input logic lib);
		stim_t s;
		s = '0;
		s.op = op;
		s.cmd = 8'($urandom);
		s.addr = 6'($urandom);
		s.data = 8'($urandom);
		s.lib = lib;
		return s;
	endfunction

	task automatic send_item(input stim_t s);
		int gap;
		serial_res_t q[$];
		gap = pick_gap();
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		operation = s.op;
		command_code = s.cmd;
		start_address = s.addr;
		data_byte = s.data;
		last_in_burst = s.lib;
		do @(posedge clk); while (full);
		serialize_item(s, q);
		if (s.exp_n != 0) begin
			q = {};
			for (int i = s.exp_n - 1; i >= 0; i--)
				q.push_back('{s.exp_bits[i], s.exp_fs && (i == s.exp_n - 1),
					s.exp_fe && (i == 0), i == 0});
		end
		foreach (q[i])
			expected_bits.push_back(q[i]);
		@(negedge clk);
	endtask

	task automatic drain_results();
		push = 1'b0;
		while (expected_bits.size() != 0)
			@(negedge clk);
	endtask

	// receiver with random stalls
	initial begin
		int stall;
		stall = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop = 1'b0;
				stall--;
			end else begin
				pop = 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : result_check
		serial_res_t got;
		serial_res_t want;
		if (arst_n && pop && !empty) begin
			got = '{serial_bit, frame_start, frame_end, last};
			if (expected_bits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: bit %b start %b end %b last %b",
						got.sb, got.fs, got.fe, got.lst);
			end else begin
				want = expected_bits.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected bit %b start %b end %b last %b, got %b %b %b %b",
							want.sb, want.fs, want.fe, want.lst,
							got.sb, got.fs, got.fe, got.lst);
				end
			end
		end
	end

	initial begin
		int sent;
		int kind;
		int len;
		bit paused;
		arst_n = 1'b0;
		push = 1'b0;
		operation = 1'b0;
		command_code = '0;
		start_address = '0;
		data_byte = '0;
		last_in_burst = 1'b0;
		mismatches = 0;
		burst_is_open = 1'b0;
		quiet = 1'b0;
		sent = 0;
		paused = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_item(DIRECTED[i]);
		drain_results();

		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				quiet = ~quiet;
			if (!paused && sent >= RAND_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// well-formed burst closed by last_in_burst
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_item(rand_item(OP_DATA, k == len - 1));
				sent += len;
			end else if (kind < 9) begin
				send_item(rand_item(OP_COMMAND, 1'($urandom_range(0, 1))));
				sent++;
			end else begin
				// burst left open and cut by a command
				len = $urandom_range(1, 4);
				for (int k = 0; k < len; k++)
					send_item(rand_item(OP_DATA, 1'b0));
				send_item(rand_item(OP_COMMAND, 1'($urandom_range(0, 1))));
				sent += len + 1;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_bits.size() == 0)
			$display("lcd_controller_serial_writer_unit test passed");
		else
			$display("lcd_controller_serial_writer_unit test failed");
		$finish;
	end

endmodule

### lcd_controller_serial_writer_unit.f
rtl/lcdsw_pkg.sv
rtl/lcdsw_front.sv
rtl/lcdsw_fifo.sv
rtl/lcdsw_back.sv
rtl/lcd_controller_serial_writer_unit.sv
rtl/lcdsw_checker.sv
sim/tb_top.sv
